// ===== sv/assert_macros.svh =====
// Assertion macros used by the interpreter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define BFI_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define BFI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bfi_pkg.sv =====
// Types, codes and the character decoder of the interpreter core.
package bfi_pkg;

  localparam int unsigned OpW = 4;
  localparam int unsigned PcOutW = 11;

  localparam logic [OpW-1:0] OP_NOP   = 4'd0;
  localparam logic [OpW-1:0] OP_RIGHT = 4'd1;
  localparam logic [OpW-1:0] OP_LEFT  = 4'd2;
  localparam logic [OpW-1:0] OP_INC   = 4'd3;
  localparam logic [OpW-1:0] OP_DEC   = 4'd4;
  localparam logic [OpW-1:0] OP_OUT   = 4'd5;
  localparam logic [OpW-1:0] OP_IN    = 4'd6;
  localparam logic [OpW-1:0] OP_OPEN  = 4'd7;
  localparam logic [OpW-1:0] OP_CLOSE = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_BRACKET = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] in_byte;
  } in_req_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              took_input;
    logic [1:0]        status;
    logic [PcOutW-1:0] program_counter;
  } out_res_t;

  function automatic logic [OpW-1:0] bfi_decode(input logic [7:0] c);
    logic [OpW-1:0] op;
    unique case (c)
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== sv/bfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/brainfuck_interpreter_core.sv =====
// Interpreter core: tape machine driven by load, start, step and clear requests.
//
// Requests enter on in_req when start is high and busy is low. Every request
// gives exactly one result on out_res, shown for one cycle with out_strobe.
// The receiver cannot stall; results are never held.
// Path from the accepting edge to the strobe:
//   load other than a matched ']', clear program: strobe in the next cycle
//   load of a matched ']': stack pop, two match-store writes (S_LDPOP, S_LDPOP2)
//   step that executes: program, match and tape read, then execute in S_EXEC
//   step that is blocked or past the end: strobe in the next cycle
//   start: tape sweep in S_CLR, one tape cell is zeroed per cycle
// A new request may be accepted in the cycle its predecessor's result shows;
// the time a step takes is set by the registered memory read.
// After reset the tape is swept to zero with busy high;
// this sweep gives no result.
// Program, match, bracket stack and tape each live in one RAM.
module brainfuck_interpreter_core
  import bfi_pkg::*;
#(
  parameter int unsigned DATA_DEPTH  = 1024,
  parameter int unsigned PROG_DEPTH  = 1024,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  `include "assert_macros.svh"

  localparam int unsigned DW  = $clog2(DATA_DEPTH);
  localparam int unsigned PAW = $clog2(PROG_DEPTH);
  localparam int unsigned PCW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned STW = $clog2(STACK_DEPTH);
  localparam int unsigned SW  = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LDPOP  = 3'd1;
  localparam logic [2:0] S_LDPOP2 = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_CLR    = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [PCW-1:0] len_r, len_nxt;
  logic [PCW-1:0] ci_r, ci_nxt;
  logic [SW-1:0]  sp_r, sp_nxt;
  logic [DW-1:0]  dp_r, dp_nxt;
  logic           err_r, err_nxt;
  logic [DW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           clr_report_r, clr_report_nxt;
  in_req_t        req_r, req_nxt;
  logic [PAW-1:0] open_r, open_nxt;
  logic           strobe_r, strobe_nxt;
  out_res_t       res_r, res_nxt;

  logic           prog_we, match_we, stk_we, tape_we;
  logic [PAW-1:0] prog_waddr, match_waddr, prog_raddr;
  logic [OpW-1:0] prog_wdata, prog_rdata;
  logic [PAW-1:0] match_wdata, match_rdata;
  logic [STW-1:0] stk_waddr, stk_raddr;
  logic [PAW-1:0] stk_wdata, stk_rdata;
  logic [DW-1:0]  tape_waddr, tape_raddr;
  logic [7:0]     tape_wdata, tape_rdata;

  logic           accept;
  logic [OpW-1:0] ld_op;
  logic [PAW-1:0] at;
  logic [PAW-1:0] jump;
  logic [SW-1:0]  sp_dec;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign ld_op  = bfi_decode(in_req.char_code);
  assign at     = len_r[PAW-1:0];
  assign sp_dec = sp_r - SW'(1);

  // Sequence requests and drive the memory ports
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    ci_nxt         = ci_r;
    sp_nxt         = sp_r;
    dp_nxt         = dp_r;
    err_nxt        = err_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    req_nxt        = req_r;
    open_nxt       = open_r;
    strobe_nxt     = 1'b0;
    res_nxt        = res_r;
    prog_we        = 1'b0;
    prog_waddr     = at;
    prog_wdata     = ld_op;
    prog_raddr     = ci_r[PAW-1:0];
    match_we       = 1'b0;
    match_waddr    = at;
    match_wdata    = '0;
    stk_we         = 1'b0;
    stk_waddr      = sp_r[STW-1:0];
    stk_wdata      = at;
    stk_raddr      = sp_dec[STW-1:0];
    tape_we        = 1'b0;
    tape_waddr     = dp_r;
    tape_wdata     = '0;
    tape_raddr     = dp_r;
    jump           = ci_r[PAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_req;
          res_nxt    = '0;
          strobe_nxt = 1'b1;
          unique case (in_req.kind)
            KIND_LOAD: begin
              res_nxt.program_counter = PcOutW'(len_r);
              if (len_r >= PCW'(PROG_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else if (ld_op == OP_OPEN && sp_r >= SW'(STACK_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else if (ld_op == OP_CLOSE && sp_r != '0) begin
                // pop the open bracket, finish in S_LDPOP and S_LDPOP2
                strobe_nxt = 1'b0;
                state_nxt  = S_LDPOP;
              end else begin
                prog_we  = 1'b1;
                match_we = 1'b1;
                len_nxt  = len_r + PCW'(1);
                res_nxt.program_counter = PcOutW'(len_r + PCW'(1));
                if (ld_op == OP_OPEN) begin
                  stk_we = 1'b1;
                  sp_nxt = sp_r + SW'(1);
                end
                if (ld_op == OP_CLOSE) begin
                  err_nxt        = 1'b1;
                  res_nxt.status = ST_BRACKET;
                end
              end
            end
            KIND_START: begin
              strobe_nxt     = 1'b0;
              dp_nxt         = '0;
              ci_nxt         = '0;
              err_nxt        = err_r || (sp_r != '0);
              clr_addr_nxt   = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLR;
            end
            KIND_STEP: begin
              res_nxt.program_counter = PcOutW'(ci_r);
              if (err_r || sp_r != '0) begin
                res_nxt.status = ST_BRACKET;
              end else if (ci_r >= len_r) begin
                res_nxt.status = ST_END;
              end else begin
                strobe_nxt = 1'b0;
                state_nxt  = S_EXEC;
              end
            end
            KIND_CLEAR: begin
              len_nxt = '0;
              sp_nxt  = '0;
              err_nxt = 1'b0;
              ci_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_LDPOP: begin
        // store the close command and point it at its open bracket
        prog_we     = 1'b1;
        prog_wdata  = OP_CLOSE;
        match_we    = 1'b1;
        match_wdata = stk_rdata;
        open_nxt    = stk_rdata;
        state_nxt   = S_LDPOP2;
      end
      S_LDPOP2: begin
        match_we    = 1'b1;
        match_waddr = open_r;
        match_wdata = at;
        len_nxt     = len_r + PCW'(1);
        sp_nxt      = sp_dec;
        res_nxt.program_counter = PcOutW'(len_r + PCW'(1));
        strobe_nxt  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_EXEC: begin
        case (prog_rdata)
          OP_RIGHT: dp_nxt = (dp_r == DW'(DATA_DEPTH - 1)) ? '0 : dp_r + DW'(1);
          OP_LEFT:  dp_nxt = (dp_r == '0) ? DW'(DATA_DEPTH - 1) : dp_r - DW'(1);
          OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          OP_OUT: begin
            res_nxt.out_valid = 1'b1;
            res_nxt.out_byte  = tape_rdata;
          end
          OP_IN: begin
            tape_we            = 1'b1;
            tape_wdata         = req_r.in_byte;
            res_nxt.took_input = 1'b1;
          end
          OP_OPEN:  if (tape_rdata == 8'd0) jump = match_rdata;
          OP_CLOSE: if (tape_rdata != 8'd0) jump = match_rdata;
          default: ;
        endcase
        ci_nxt = PCW'(jump) + PCW'(1);
        res_nxt.program_counter = PcOutW'(ci_nxt);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLR: begin
        // zero one tape cell per cycle
        tape_we    = 1'b1;
        tape_waddr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + DW'(1);
        if (clr_addr_r == DW'(DATA_DEPTH - 1)) begin
          strobe_nxt     = clr_report_r;
          res_nxt.status = err_r ? ST_BRACKET : ST_OK;
          res_nxt.program_counter = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      len_r        <= '0;
      ci_r         <= '0;
      sp_r         <= '0;
      dp_r         <= '0;
      err_r        <= 1'b0;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      ci_r         <= ci_nxt;
      sp_r         <= sp_nxt;
      dp_r         <= dp_nxt;
      err_r        <= err_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      strobe_r     <= strobe_nxt;
    end
    req_r  <= req_nxt;
    open_r <= open_nxt;
    res_r  <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  bfi_ram #(.WIDTH(OpW), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
    .raddr(prog_raddr), .rdata(prog_rdata)
  );

  bfi_ram #(.WIDTH(PAW), .DEPTH(PROG_DEPTH)) u_match (
    .clk(clk), .we(match_we), .waddr(match_waddr), .wdata(match_wdata),
    .raddr(prog_raddr), .rdata(match_rdata)
  );

  bfi_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  bfi_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_tape (
    .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(tape_raddr), .rdata(tape_rdata)
  );

  `BFI_ASSERT_ALWAYS(a_sp_bound, sp_r <= SW'(STACK_DEPTH))
  `BFI_ASSERT_ALWAYS(a_len_bound, len_r <= PCW'(PROG_DEPTH))
  `BFI_ASSERT_IMPL(a_err_quiet, out_strobe && out_res.status != ST_OK, !out_res.out_valid && !out_res.took_input)
  `BFI_ASSERT_IMPL(a_exec_runs, state_r == S_EXEC, !err_r && sp_r == '0 && ci_r < len_r)

endmodule
